@@ rtl/core/checksum_frame_receiver_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the checksum frame receiver
// Concurrent checks that compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CHECKSUM_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUM_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// Hold cons in the same cycle as ante.
`define CFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checksum_frame_receiver: assertion failed");

// Hold cons in the cycle after ante.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checksum_frame_receiver: assertion failed");

`else

`define CFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Constants, status codes and controller/datapath bundles of the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int PAYLOAD_CAP  = 50;
  localparam int OFF_W        = $clog2(PAYLOAD_CAP + 5);
  localparam int CMP_W        = ((CNT_W > 8) ? CNT_W : 8) + 2;

  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [7:0] SUM_GOOD     = 8'hFF;
  localparam logic [7:0] FUNC_RESPOND = 8'hB0;
  localparam logic [7:0] FUNC_LAST    = 8'hB3;
  localparam logic [5:0] MAXP_RESET   = 6'd50;
  localparam logic [5:0] MAXP_CAP     = 6'd50;
  localparam int         HDR_BYTES    = 4;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FORMAT = 3'd1,
    ST_CHECK  = 3'd2,
    ST_SEQ    = 3'd3,
    ST_LENGTH = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    store;       // write the accepted byte
    logic    scan_init;   // first candidate, default error
    logic    base_inc;    // next candidate
    logic    off_inc;
    logic    off_clr;
    logic    off_pay;     // point at first payload byte
    logic    ld_fn;
    logic    ld_sq;
    logic    ld_len;
    logic    sum_clr;
    logic    sum_acc;
    logic    ld_chk;
    logic    set_err;
    status_t err_code;
    logic    seq_latch;   // first good checksum starts the sequence
    logic    commit_ok;
    logic    emit_pay;
    logic    emit_fail;
  } cfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic base_end;
    logic is_sync;
    logic hdr_short;
    logic fn_bad;
    logic len_big;
    logic frame_short;
    logic sum_last;
    logic sum_bad;
    logic seq_bad;
    logic pay_last;
    logic len_zero;
    logic out_free;
  } cfr_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/cfr_channels.sv @@
// ----------------------------------------------------------------------------
// Receiver channels
// Valid/ready channel bundles for bytes in, results out and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] frame_function;
  logic [7:0] frame_sequence;
  logic [5:0] payload_length;
  logic [7:0] frame_check;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       last;
  logic [7:0] error_run;
  logic [7:0] expected_sequence;

  modport source (
    output valid, output status, output frame_function, output frame_sequence,
    output payload_length, output frame_check, output payload_byte,
    output payload_valid, output last, output error_run, output expected_sequence,
    input ready
  );
  modport sink (
    input valid, input status, input frame_function, input frame_sequence,
    input payload_length, input frame_check, input payload_byte,
    input payload_valid, input last, input error_run, input expected_sequence,
    output ready
  );
endinterface

interface cfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] max_payload;

  modport source (output valid, output max_payload, input ready);
  modport sink   (input valid, input max_payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cfr_datapath.sv @@
// ----------------------------------------------------------------------------
// cfr_datapath
// Byte store, scan pointers, header and checksum registers, result stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "checksum_frame_receiver_macros.svh"

module cfr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  cfr_pkg::cfr_cmd_t   cmd,
  output cfr_pkg::cfr_sts_t   sts,
  input  logic [7:0]          in_rx_byte,
  cfr_cfg_if.sink             cfg_ch,
  cfr_out_if.source           out_ch
);

  logic [7:0]                   mem [cfr_pkg::BUFFER_BYTES];
  logic [7:0]                   rd_data_r;
  logic [cfr_pkg::ADDR_W-1:0]   rd_addr;

  logic [cfr_pkg::CNT_W-1:0]    fill_r, fill_nxt;
  logic [cfr_pkg::CNT_W-1:0]    base_r, base_nxt;
  logic [cfr_pkg::OFF_W-1:0]    off_r, off_nxt;
  logic [7:0]                   fn_r, sq_r, len_r, sum_r, chk_r;
  cfr_pkg::status_t             err_r;
  logic                         started_r, started_nxt;
  logic [7:0]                   next_seq_r, next_seq_nxt;
  logic [7:0]                   fail_r, fail_nxt;
  logic [5:0]                   max_payload_r;
  logic [5:0]                   limit;
  logic [7:0]                   eff_seq;
  logic                         store_ok;

  logic                         out_valid_r;
  logic [2:0]                   out_status_r;
  logic [7:0]                   out_fn_r, out_sq_r, out_chk_r, out_pb_r;
  logic [5:0]                   out_len_r;
  logic                         out_pv_r, out_last_r;
  logic [7:0]                   out_run_r, out_exp_r;

  assign cfg_ch.ready = 1'b1;
  assign limit        = (max_payload_r > cfr_pkg::MAXP_CAP) ? cfr_pkg::MAXP_CAP
                                                            : max_payload_r;
  assign eff_seq      = started_r ? next_seq_r : sq_r;
  assign store_ok     = cmd.store && (fill_r < cfr_pkg::CNT_W'(cfr_pkg::BUFFER_BYTES));

  // status towards the controller
  always_comb begin
    sts.base_end    = (base_r >= fill_r);
    sts.is_sync     = (rd_data_r == cfr_pkg::SYNC_BYTE);
    sts.hdr_short   = (cfr_pkg::CMP_W'(base_r) + cfr_pkg::CMP_W'(3)
                       >= cfr_pkg::CMP_W'(fill_r));
    sts.fn_bad      = (fn_r < cfr_pkg::FUNC_RESPOND) || (fn_r > cfr_pkg::FUNC_LAST);
    sts.len_big     = (len_r > {2'b00, limit});
    sts.frame_short = (cfr_pkg::CMP_W'(base_r) + cfr_pkg::CMP_W'(cfr_pkg::HDR_BYTES)
                       + cfr_pkg::CMP_W'(len_r) >= cfr_pkg::CMP_W'(fill_r));
    sts.sum_last    = (cfr_pkg::CMP_W'(off_r) == cfr_pkg::CMP_W'(len_r)
                       + cfr_pkg::CMP_W'(cfr_pkg::HDR_BYTES));
    sts.sum_bad     = (sum_r != cfr_pkg::SUM_GOOD);
    sts.seq_bad     = (eff_seq != sq_r) && (fn_r != cfr_pkg::FUNC_RESPOND);
    sts.pay_last    = (cfr_pkg::CMP_W'(off_r) + cfr_pkg::CMP_W'(1) == cfr_pkg::CMP_W'(len_r)
                       + cfr_pkg::CMP_W'(cfr_pkg::HDR_BYTES));
    sts.len_zero    = (len_r == 8'd0);
    sts.out_free    = !out_valid_r || out_ch.ready;
  end

  // pointers, fill level and sequence bookkeeping
  always_comb begin
    fill_nxt     = fill_r;
    base_nxt     = base_r;
    off_nxt      = off_r;
    started_nxt  = started_r;
    next_seq_nxt = next_seq_r;
    fail_nxt     = fail_r;
    if (store_ok) begin
      fill_nxt = fill_r + cfr_pkg::CNT_W'(1);
    end
    if (cmd.scan_init) begin
      base_nxt = '0;
      off_nxt  = '0;
    end
    if (cmd.base_inc) begin
      base_nxt = base_r + cfr_pkg::CNT_W'(1);
      off_nxt  = '0;
    end
    if (cmd.off_inc) begin
      off_nxt = off_r + cfr_pkg::OFF_W'(1);
    end
    if (cmd.off_clr) begin
      off_nxt = '0;
    end
    if (cmd.off_pay) begin
      off_nxt = cfr_pkg::OFF_W'(cfr_pkg::HDR_BYTES);
    end
    if (cmd.seq_latch) begin
      started_nxt  = 1'b1;
      next_seq_nxt = eff_seq;
    end
    if (cmd.commit_ok) begin
      fail_nxt     = 8'd0;
      next_seq_nxt = (fn_r == cfr_pkg::FUNC_RESPOND) ? eff_seq : eff_seq + 8'd1;
    end
    if (cmd.emit_fail) begin
      fail_nxt = fail_r + 8'd1;
      fill_nxt = '0;
    end
    if (cmd.emit_pay && (sts.len_zero || sts.pay_last)) begin
      fill_nxt = '0;
    end
  end

  // read one byte ahead: address follows the next pointer values
  assign rd_addr = base_nxt[cfr_pkg::ADDR_W-1:0] + cfr_pkg::ADDR_W'(off_nxt);

  always_ff @(posedge clk) begin
    if (store_ok) begin
      mem[fill_r[cfr_pkg::ADDR_W-1:0]] <= in_rx_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      started_r     <= 1'b0;
      next_seq_r    <= 8'd0;
      fail_r        <= 8'd0;
      max_payload_r <= cfr_pkg::MAXP_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      started_r  <= started_nxt;
      next_seq_r <= next_seq_nxt;
      fail_r     <= fail_nxt;
      if (cfg_ch.valid) begin
        max_payload_r <= cfg_ch.max_payload;
      end
      if (cmd.emit_pay || cmd.emit_fail) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    off_r  <= off_nxt;
    if (cmd.ld_fn) begin
      fn_r <= rd_data_r;
    end
    if (cmd.ld_sq) begin
      sq_r <= rd_data_r;
    end
    if (cmd.ld_len) begin
      len_r <= rd_data_r;
    end
    if (cmd.sum_clr) begin
      sum_r <= 8'd0;
    end else if (cmd.sum_acc) begin
      sum_r <= sum_r + rd_data_r;
    end
    if (cmd.ld_chk) begin
      chk_r <= rd_data_r;
    end
    if (cmd.scan_init) begin
      err_r <= cfr_pkg::ST_FORMAT;
    end else if (cmd.set_err) begin
      err_r <= cmd.err_code;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (cmd.emit_pay) begin
      out_status_r <= cfr_pkg::ST_OK;
      out_fn_r     <= fn_r;
      out_sq_r     <= sq_r;
      out_len_r    <= len_r[5:0];
      out_chk_r    <= chk_r;
      out_pb_r     <= sts.len_zero ? 8'd0 : rd_data_r;
      out_pv_r     <= !sts.len_zero;
      out_last_r   <= sts.len_zero || sts.pay_last;
      out_run_r    <= fail_r;
      out_exp_r    <= next_seq_r;
    end else if (cmd.emit_fail) begin
      out_status_r <= err_r;
      out_fn_r     <= 8'd0;
      out_sq_r     <= 8'd0;
      out_len_r    <= 6'd0;
      out_chk_r    <= 8'd0;
      out_pb_r     <= 8'd0;
      out_pv_r     <= 1'b0;
      out_last_r   <= 1'b1;
      out_run_r    <= fail_r + 8'd1;
      out_exp_r    <= next_seq_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.frame_function    = out_fn_r;
  assign out_ch.frame_sequence    = out_sq_r;
  assign out_ch.payload_length    = out_len_r;
  assign out_ch.frame_check       = out_chk_r;
  assign out_ch.payload_byte      = out_pb_r;
  assign out_ch.payload_valid     = out_pv_r;
  assign out_ch.last              = out_last_r;
  assign out_ch.error_run         = out_run_r;
  assign out_ch.expected_sequence = out_exp_r;

  `CFR_ASSERT_IMPLIES(a_fill_range, clk, rst_n, 1'b1, fill_r <= cfr_pkg::CNT_W'(cfr_pkg::BUFFER_BYTES))
  `CFR_ASSERT_IMPLIES(a_fail_single, clk, rst_n, out_valid_r && (out_status_r != cfr_pkg::ST_OK), out_last_r && !out_pv_r)
  `CFR_ASSERT_NEXT(a_commit_clears, clk, rst_n, cmd.commit_ok, fail_r == 8'd0)

endmodule

`default_nettype wire

@@ rtl/core/cfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfr_ctrl
// Sequencer for byte collection, frame scan and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "checksum_frame_receiver_macros.svh"

module cfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_end,
  output logic                in_ready,
  input  cfr_pkg::cfr_sts_t   sts,
  output cfr_pkg::cfr_cmd_t   cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SCAN = 11'b00000000010,
    S_SYNC = 11'b00000000100,
    S_FN   = 11'b00000001000,
    S_SQ   = 11'b00000010000,
    S_LEN  = 11'b00000100000,
    S_HCHK = 11'b00001000000,
    S_SUM  = 11'b00010000000,
    S_SCHK = 11'b00100000000,
    S_EMIT = 11'b01000000000,
    S_FAIL = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_end) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        state_nxt = sts.base_end ? S_FAIL : S_SYNC;
      end
      S_SYNC: begin
        priority if (!sts.is_sync) begin
          cmd.base_inc = 1'b1;
          state_nxt    = S_SCAN;
        end else if (sts.hdr_short) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = cfr_pkg::ST_FORMAT;
          cmd.base_inc = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          cmd.off_inc = 1'b1;
          state_nxt   = S_FN;
        end
      end
      S_FN: begin
        cmd.ld_fn   = 1'b1;
        cmd.off_inc = 1'b1;
        state_nxt   = S_SQ;
      end
      S_SQ: begin
        cmd.ld_sq   = 1'b1;
        cmd.off_inc = 1'b1;
        state_nxt   = S_LEN;
      end
      S_LEN: begin
        cmd.ld_len  = 1'b1;
        cmd.off_clr = 1'b1;
        cmd.sum_clr = 1'b1;
        state_nxt   = S_HCHK;
      end
      S_HCHK: begin
        priority if (sts.fn_bad) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = cfr_pkg::ST_FORMAT;
          cmd.base_inc = 1'b1;
          state_nxt    = S_SCAN;
        end else if (sts.len_big) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = cfr_pkg::ST_LENGTH;
          cmd.base_inc = 1'b1;
          state_nxt    = S_SCAN;
        end else if (sts.frame_short) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = cfr_pkg::ST_FORMAT;
          cmd.base_inc = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_acc = 1'b1;
        if (sts.sum_last) begin
          cmd.ld_chk  = 1'b1;
          cmd.off_pay = 1'b1;
          state_nxt   = S_SCHK;
        end else begin
          cmd.off_inc = 1'b1;
        end
      end
      S_SCHK: begin
        priority if (sts.sum_bad) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = cfr_pkg::ST_CHECK;
          cmd.base_inc = 1'b1;
          state_nxt    = S_SCAN;
        end else if (sts.seq_bad) begin
          cmd.seq_latch = 1'b1;
          cmd.set_err   = 1'b1;
          cmd.err_code  = cfr_pkg::ST_SEQ;
          cmd.base_inc  = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.seq_latch = 1'b1;
          cmd.commit_ok = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_pay = 1'b1;
          if (sts.len_zero || sts.pay_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.off_inc = 1'b1;
          end
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.emit_fail = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CFR_ASSERT_NEXT(a_fail_to_idle, clk, rst_n, cmd.emit_fail, state_r == S_IDLE)
  `CFR_ASSERT_NEXT(a_end_starts_scan, clk, rst_n, in_valid && in_ready && in_end, state_r == S_SCAN)
  `CFR_ASSERT_IMPLIES(a_emit_needs_room, clk, rst_n, cmd.emit_pay || cmd.emit_fail, sts.out_free)

endmodule

`default_nettype wire

@@ rtl/core/checksum_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// checksum_frame_receiver
// Collects a received byte buffer and extracts the first valid frame from it.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per received byte; end_of_buffer marks the final byte.
//            Bytes beyond the 64-byte store are dropped; their end mark still
//            starts the scan.
//   out_ch : one request per payload byte of the accepted frame, or a single
//            request for an empty payload or a failed scan; last flags the end.
//   cfg_ch : max_payload, always ready; write it only while the block is idle.
// Flow: bytes without end mark stream back to back. The scan reads the store
//   through one registered port, stepping S_SCAN and S_SYNC per non-sync byte,
//   S_SCAN to S_HCHK per header, S_SUM over the frame and its checksum, then
//   S_SCHK. Results leave at one per cycle unless out_ch stalls. in_ch.ready
//   stays low from the end mark until the last result enters the output stage.
// Reset clears the fill level, sequence tracking, error run and the limit
// (back to 50). A stalled out_ch holds the current result and pauses the
// controller; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module checksum_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  cfr_cfg_if.sink    cfg_ch,
  cfr_in_if.sink     in_ch,
  cfr_out_if.source  out_ch
);

  // command and status bundles between sequencer and datapath
  cfr_pkg::cfr_cmd_t cmd;
  cfr_pkg::cfr_sts_t sts;

  // sequencer: handshake on the byte channel, scan and emit ordering
  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_end   (in_ch.end_of_buffer),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: byte store, checksum, sequence state and the result register
  cfr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_rx_byte (in_ch.rx_byte),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
